@@ rtl/pcbd_pkg.sv @@
// Package: constants, codes and control/status types of the prefix code bit decoder.
package pcbd_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_CODE_LEN  = 32;
  localparam int CODE_W        = 32;
  localparam int LEN_W         = 6;
  localparam int SYM_W         = 8;
  localparam int BYTE_W        = 8;
  localparam int KIND_W        = 2;
  localparam int ST_W          = 2;
  localparam int LEN_LIMIT     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W       = CODE_W + LEN_W + SYM_W;
  localparam int BITS_W        = $clog2(BYTE_W + 1);
  localparam int IN_DATA_W     = 56;
  localparam int OUT_DATA_W    = 8;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;

  localparam logic [ST_W-1:0] ST_SYM      = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERLONG = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

  localparam logic [SYM_W-1:0] END_SYM_RESET = 8'd3;

  typedef struct packed {
    logic            capture;
    logic            clear;
    logic            scan_start;
    logic            shift_bit;
    logic            acc_clear;
    logic            set_stop;
    logic            tbl_write_hit;
    logic            tbl_append;
    logic            res_new;
    logic [ST_W-1:0] res_st;
    logic            flush;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              stopped;
    logic              load_len_ok;
    logic              byte_done;
    logic              at_limit;
    logic              scan_busy;
    logic              scan_hit;
    logic              hit_is_end;
    logic              tbl_full;
    logic              out_free;
    logic              pnd_valid;
  } sts_t;

endpackage

@@ rtl/pcbd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pcbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pcbd_ctrl.sv @@
// Controller state machine: sequences clear, load and per-bit decode of one item at a time.
module pcbd_ctrl
  import pcbd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_LSCAN = 3'd2;
  localparam logic [2:0] S_DBIT  = 3'd3;
  localparam logic [2:0] S_DSCAN = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       can_res;

  assign can_res   = !sts.pnd_valid || sts.out_free;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_st = ST_SYM;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.kind)
          KIND_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
          KIND_LOAD: begin
            if (sts.load_len_ok) begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_LSCAN;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          KIND_DATA: begin
            state_nxt = sts.stopped ? S_IDLE : S_DBIT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LSCAN: begin
        if (!sts.scan_busy) begin
          if (sts.scan_hit) begin
            cmd.tbl_write_hit = 1'b1;
            state_nxt         = S_IDLE;
          end else if (sts.tbl_full) begin
            cmd.res_new  = 1'b1;
            cmd.res_st   = ST_FULL;
            cmd.set_stop = 1'b1;
            state_nxt    = S_FLUSH;
          end else begin
            cmd.tbl_append = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_DBIT: begin
        if (sts.byte_done) begin
          state_nxt = S_FLUSH;
        end else if (sts.at_limit) begin
          if (can_res) begin
            cmd.res_new  = 1'b1;
            cmd.res_st   = ST_OVERLONG;
            cmd.set_stop = 1'b1;
            state_nxt    = S_FLUSH;
          end
        end else begin
          cmd.shift_bit  = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_DSCAN;
        end
      end
      S_DSCAN: begin
        if (!sts.scan_busy) begin
          if (!sts.scan_hit) begin
            state_nxt = S_DBIT;
          end else if (sts.hit_is_end) begin
            cmd.acc_clear = 1'b1;
            cmd.set_stop  = 1'b1;
            state_nxt     = S_FLUSH;
          end else if (can_res) begin
            cmd.acc_clear = 1'b1;
            cmd.res_new   = 1'b1;
            state_nxt     = S_DBIT;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.pnd_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/pcbd_dp.sv @@
// Datapath: code table, table scan unit, bit accumulator, pending result and output register.
module pcbd_dp
  import pcbd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [CODE_W-1:0]   in_code_bits,
  input  logic [LEN_W-1:0]    in_code_length,
  input  logic [SYM_W-1:0]    in_entry_symbol,
  input  logic [BYTE_W-1:0]   in_data_byte,
  input  logic                cfg_valid,
  input  logic [SYM_W-1:0]    cfg_data,
  input  logic                out_tready,
  output logic                out_valid,
  output logic [SYM_W-1:0]    out_symbol,
  output logic [ST_W-1:0]     out_status,
  output logic                out_last
);

  logic [CNT_W-1:0]  cnt_r;
  logic [CODE_W-1:0] acc_r;
  logic [LEN_W-1:0]  alen_r;
  logic              stop_r;
  logic [SYM_W-1:0]  endsym_r;

  logic [KIND_W-1:0] kind_r;
  logic [CODE_W-1:0] key_code_r;
  logic [LEN_W-1:0]  key_len_r;
  logic [SYM_W-1:0]  sym_r;
  logic [BYTE_W-1:0] byte_r;
  logic [BITS_W-1:0] bits_r;
  logic              len_ok_r;

  logic              busy_r;
  logic              inflight_r;
  logic [CNT_W-1:0]  addr_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [SYM_W-1:0]  hit_sym_r;

  logic              pnd_v_r;
  logic [SYM_W-1:0]  pnd_sym_r;
  logic [ST_W-1:0]   pnd_st_r;

  logic              out_v_r;
  logic [SYM_W-1:0]  out_sym_r;
  logic [ST_W-1:0]   out_st_r;
  logic              out_last_r;

  logic [CODE_W-1:0] mask;
  logic              len_ok;
  logic [CODE_W-1:0] cmp_code;
  logic [LEN_W-1:0]  cmp_len;
  logic [ENTRY_W-1:0] rdata;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic [SYM_W-1:0]  rd_sym;
  logic              match;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic              out_free;
  logic [SYM_W-1:0]  res_sym;

  assign len_ok = (in_code_length != '0) && (in_code_length <= LEN_W'(LEN_LIMIT));

  always_comb begin
    if (in_code_length >= LEN_W'(CODE_W)) begin
      mask = '1;
    end else begin
      mask = (CODE_W'(1) << in_code_length) - CODE_W'(1);
    end
  end

  assign cmp_code = (kind_r == KIND_LOAD) ? key_code_r : acc_r;
  assign cmp_len  = (kind_r == KIND_LOAD) ? key_len_r  : alen_r;
  assign {rd_code, rd_len, rd_sym} = rdata;
  assign match = inflight_r && (rd_len == cmp_len) && (rd_code == cmp_code);

  assign ram_we    = cmd.tbl_write_hit || cmd.tbl_append;
  assign ram_waddr = cmd.tbl_write_hit ? hit_idx_r : cnt_r[IDX_W-1:0];

  pcbd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_tbl (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({key_code_r, key_len_r, sym_r}),
    .raddr(addr_r[IDX_W-1:0]),
    .rdata(rdata)
  );

  // item capture and decode state
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= in_kind;
      key_code_r <= in_code_bits & mask;
      key_len_r  <= in_code_length;
      sym_r      <= in_entry_symbol;
      byte_r     <= in_data_byte;
      bits_r     <= BITS_W'(BYTE_W);
    end else if (cmd.shift_bit) begin
      byte_r <= byte_r << 1;
      bits_r <= bits_r - BITS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      acc_r    <= '0;
      alen_r   <= '0;
      stop_r   <= 1'b0;
      endsym_r <= END_SYM_RESET;
    end else begin
      if (cfg_valid) begin
        endsym_r <= cfg_data;
      end
      if (cmd.clear) begin
        cnt_r  <= '0;
        acc_r  <= '0;
        alen_r <= '0;
        stop_r <= 1'b0;
      end else begin
        if (cmd.tbl_append) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (cmd.set_stop) begin
          stop_r <= 1'b1;
        end
        if (cmd.acc_clear) begin
          acc_r  <= '0;
          alen_r <= '0;
        end else if (cmd.shift_bit) begin
          acc_r  <= {acc_r[CODE_W-2:0], byte_r[BYTE_W-1]};
          alen_r <= alen_r + LEN_W'(1);
        end
      end
    end
  end

  // table scan: one read issued per cycle, compare on the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      inflight_r <= 1'b0;
      hit_r      <= 1'b0;
      addr_r     <= '0;
    end else if (cmd.scan_start) begin
      busy_r     <= 1'b1;
      inflight_r <= 1'b0;
      hit_r      <= 1'b0;
      addr_r     <= '0;
    end else if (busy_r) begin
      if (match) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= rd_idx_r;
        hit_sym_r  <= rd_sym;
        busy_r     <= 1'b0;
        inflight_r <= 1'b0;
      end else if (addr_r < cnt_r) begin
        inflight_r <= 1'b1;
        rd_idx_r   <= addr_r[IDX_W-1:0];
        addr_r     <= addr_r + CNT_W'(1);
      end else begin
        inflight_r <= 1'b0;
        if (!inflight_r) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // pending result and output register
  assign out_free = !out_v_r || out_tready;
  assign res_sym  = (cmd.res_st == ST_SYM) ? hit_sym_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pnd_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if ((cmd.res_new && pnd_v_r) || cmd.flush) begin
        out_v_r    <= 1'b1;
        out_sym_r  <= pnd_sym_r;
        out_st_r   <= pnd_st_r;
        out_last_r <= cmd.flush;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cmd.res_new) begin
        pnd_v_r   <= 1'b1;
        pnd_sym_r <= res_sym;
        pnd_st_r  <= cmd.res_st;
      end else if (cmd.flush) begin
        pnd_v_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_v_r;
  assign out_symbol = out_sym_r;
  assign out_status = out_st_r;
  assign out_last   = out_last_r;

  always_comb begin
    sts.kind        = kind_r;
    sts.stopped     = stop_r;
    sts.load_len_ok = len_ok_r;
    sts.byte_done   = (bits_r == '0);
    sts.at_limit    = (alen_r >= LEN_W'(LEN_LIMIT));
    sts.scan_busy   = busy_r;
    sts.scan_hit    = hit_r;
    sts.hit_is_end  = (hit_sym_r == endsym_r);
    sts.tbl_full    = (cnt_r == CNT_W'(TABLE_ENTRIES));
    sts.out_free    = out_free;
    sts.pnd_valid   = pnd_v_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      len_ok_r <= len_ok;
    end
  end

endmodule

@@ rtl/prefix_code_bit_decoder_top.sv @@
// Top level of the table-driven prefix code bit decoder.
// One item is taken at a time; in_tready is high only while the block is idle, but a finished
// result may still wait in the output register. Every code lookup scans the code table one
// entry per cycle through its single read port, stopping at the first match. Results of a
// byte leave one beat at a time, the last one with tlast set; a full output register delays
// the next beat. The table holds 256 entries and needs no clearing pass after reset.
module prefix_code_bit_decoder_top
  import pcbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] code_bits, [37:32] code_length, [45:38] entry_symbol, [53:46] data_byte
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] out_symbol
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [ST_W-1:0]       out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SYM_W-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  pcbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcbd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_tuser),
    .in_code_bits   (in_tdata[CODE_W-1:0]),
    .in_code_length (in_tdata[CODE_W+LEN_W-1:CODE_W]),
    .in_entry_symbol(in_tdata[CODE_W+LEN_W+SYM_W-1:CODE_W+LEN_W]),
    .in_data_byte   (in_tdata[CODE_W+LEN_W+SYM_W+BYTE_W-1:CODE_W+LEN_W+SYM_W]),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_tready     (out_tready),
    .out_valid      (out_tvalid),
    .out_symbol     (out_tdata),
    .out_status     (out_tuser),
    .out_last       (out_tlast)
  );

endmodule
